FILE: design/pgfn_pkg.sv
// ----------------------------------------------------------------------------
// pgfn_pkg
// Shared types and constants of the geometric factor normaliser.
// ----------------------------------------------------------------------------
package pgfn_pkg;

  localparam int MAX_RING_DETECTORS = 1024;
  localparam int MAX_HALF_BLOCK     = 8;
  localparam int FACTOR_FRAC_BITS   = 16;

  localparam int COUNT_W  = 32;
  localparam int FACTOR_W = 24;
  localparam int DET_A_W  = 10;
  localparam int DET_B_W  = 11;
  localparam int MAG_W    = 12;   // |folded b|, at most 2047
  localparam int X_W      = 13;   // signed folded b

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd2;

  localparam logic [10:0] RING_RESET  = 11'd1024;
  localparam logic [4:0]  BLOCK_RESET = 5'd8;
  localparam logic        MODE_RESET  = 1'b1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_NORM = 1'b1;
  localparam logic MODE_DIV = 1'b0;
  localparam logic MODE_MUL = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;
  localparam logic [1:0] ST_DIV0 = 2'd3;

  typedef struct packed {
    logic        command;
    logic [9:0]  det_a;
    logic [10:0] det_b;
    logic [31:0] count_value;
    logic [2:0]  factor_row;
    logic [9:0]  factor_col;
    logic [23:0] factor_value;
  } in_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [1:0]  status;
  } out_t;

  // control leaving the fold pipe toward the table port
  typedef struct packed {
    logic valid;
    logic we;
    logic is_load;
    logic zero;
  } fold_ctl_t;

  // one slot of the divide pipe; num shifts out dividend bits, quotient in
  typedef struct packed {
    logic                valid;
    logic                use_div;
    logic [COUNT_W-1:0]  res;
    logic [1:0]          status;
    logic [COUNT_W-1:0]  num;
    logic [FACTOR_W-1:0] rem;
    logic [FACTOR_W-1:0] divisor;
  } div_item_t;

endpackage

FILE: design/pgfn_ram.sv
// ----------------------------------------------------------------------------
// pgfn_ram
// Single-port synchronous RAM, registered read, no reset on contents.
// ----------------------------------------------------------------------------
module pgfn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: design/pgfn_fold.sv
// ----------------------------------------------------------------------------
// pgfn_fold
// Eight-stage address pipe: a mod c, mirror fold, b mod ring, table address.
// ----------------------------------------------------------------------------
module pgfn_fold #(
  parameter int MAXR = pgfn_pkg::MAX_RING_DETECTORS,
  parameter int MAXH = pgfn_pkg::MAX_HALF_BLOCK
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_acc,
  input  pgfn_pkg::in_t                       in_item,
  input  logic [$clog2(MAXR+1)-1:0]           ring_n,
  input  logic [$clog2(2*MAXH+1)-1:0]         blk_c,
  output pgfn_pkg::fold_ctl_t                 ctl,
  output logic [$clog2(MAXH*MAXR)-1:0]        addr,
  output logic [pgfn_pkg::COUNT_W-1:0]        count,
  output logic [pgfn_pkg::FACTOR_W-1:0]       wdata
);

  localparam int NW  = $clog2(MAXR+1);
  localparam int CW  = $clog2(2*MAXH+1);
  localparam int AW  = $clog2(MAXH*MAXR);
  localparam int RW  = (MAXH > 1) ? $clog2(MAXH) : 1;
  localparam int NST = 8;

  typedef struct packed {
    logic                           valid;
    logic                           is_load;
    logic                           we;
    logic                           zero;
    logic [pgfn_pkg::DET_A_W-1:0]   a;
    logic [pgfn_pkg::DET_B_W-1:0]   b;
    logic [pgfn_pkg::COUNT_W-1:0]   count;
    logic [pgfn_pkg::FACTOR_W-1:0]  wdata;
    logic [AW-1:0]                  addr;
    logic [CW-1:0]                  fa;
    logic                           neg;
    logic [pgfn_pkg::MAG_W-1:0]     mag;
    logic [NW-1:0]                  r;
    logic [RW-1:0]                  row;
  } stage_t;

  stage_t st_r   [NST];
  stage_t st_nxt [NST];

  function automatic logic [CW-1:0] a_step(input logic [CW-1:0] r, input logic bit_i,
                                           input logic [CW-1:0] d);
    logic [CW:0] t;
    t = {r, bit_i};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[CW-1:0];
  endfunction

  function automatic logic [NW-1:0] n_step(input logic [NW-1:0] r, input logic bit_i,
                                           input logic [NW-1:0] d);
    logic [NW:0] t;
    t = {r, bit_i};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[NW-1:0];
  endfunction

  always_comb begin
    stage_t                            s;
    logic [31:0]                       ld_addr;
    logic [CW-1:0]                     cm1;
    logic signed [pgfn_pkg::X_W-1:0]   x;
    logic [NW-1:0]                     col;
    logic [31:0]                       rd_addr;

    // stage 0: capture, load address
    s          = '0;
    s.valid    = in_acc;
    s.is_load  = (in_item.command == pgfn_pkg::CMD_LOAD);
    s.zero     = (in_item.count_value == '0);
    s.a        = in_item.det_a;
    s.b        = in_item.det_b;
    s.count    = in_item.count_value;
    s.wdata    = in_item.factor_value;
    ld_addr    = 32'(in_item.factor_row) * 32'(MAXR) + 32'(in_item.factor_col);
    s.addr     = AW'(ld_addr);
    s.we       = s.is_load && (32'(in_item.factor_row) < 32'(MAXH))
                           && (32'(in_item.factor_col) < 32'(MAXR));
    st_nxt[0]  = s;

    // stages 1-2: a mod c, five bits each
    s = st_r[0];
    for (int i = 0; i < 5; i++) s.fa = a_step(s.fa, s.a[9-i], blk_c);
    st_nxt[1] = s;
    s = st_r[1];
    for (int i = 0; i < 5; i++) s.fa = a_step(s.fa, s.a[4-i], blk_c);
    st_nxt[2] = s;

    // stage 3: shift b, mirror into the lower half-block
    s   = st_r[2];
    cm1 = blk_c - CW'(1);
    x   = $signed({2'b00, s.b}) - $signed({3'b000, s.a})
        + $signed(pgfn_pkg::X_W'(s.fa));
    if (s.fa > cm1 - s.fa) begin
      s.row = RW'(cm1 - s.fa);
      x     = $signed(pgfn_pkg::X_W'(cm1)) - x;
    end else begin
      s.row = RW'(s.fa);
    end
    s.neg = x[pgfn_pkg::X_W-1];
    s.mag = s.neg ? pgfn_pkg::MAG_W'(-x) : pgfn_pkg::MAG_W'(x);
    s.r   = '0;
    st_nxt[3] = s;

    // stages 4-6: |x| mod ring, four bits each
    for (int k = 4; k < 7; k++) begin
      s = st_r[k-1];
      for (int i = 0; i < 4; i++) s.r = n_step(s.r, s.mag[11-4*(k-4)-i], ring_n);
      st_nxt[k] = s;
    end

    // stage 7: true remainder, table address
    s   = st_r[6];
    col = (s.neg && (s.r != '0)) ? ring_n - s.r : s.r;
    rd_addr = 32'(s.row) * 32'(MAXR) + 32'(col);
    if (!s.is_load) s.addr = AW'(rd_addr);
    st_nxt[7] = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) st_r[k].valid <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < NST; k++) st_r[k] <= st_nxt[k];
    end
  end

  assign ctl.valid   = st_r[NST-1].valid;
  assign ctl.we      = st_r[NST-1].we;
  assign ctl.is_load = st_r[NST-1].is_load;
  assign ctl.zero    = st_r[NST-1].zero;
  assign addr        = st_r[NST-1].addr;
  assign count       = st_r[NST-1].count;
  assign wdata       = st_r[NST-1].wdata;

endmodule

FILE: design/pgfn_divider.sv
// ----------------------------------------------------------------------------
// pgfn_divider
// Pipelined restoring divider, one quotient bit per stage; carries results
// of items that need no divide alongside.
// ----------------------------------------------------------------------------
module pgfn_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  pgfn_pkg::div_item_t   din,
  output logic                  out_valid,
  output pgfn_pkg::out_t        dout
);

  localparam int NSTEP = pgfn_pkg::COUNT_W;

  pgfn_pkg::div_item_t st_r   [NSTEP+1];
  pgfn_pkg::div_item_t st_nxt [NSTEP+1];

  always_comb begin
    logic [pgfn_pkg::FACTOR_W:0] t;
    logic                        ge;
    st_nxt[0] = din;
    for (int k = 1; k <= NSTEP; k++) begin
      st_nxt[k] = st_r[k-1];
      t  = {st_r[k-1].rem, st_r[k-1].num[NSTEP-1]};
      ge = (t >= {1'b0, st_r[k-1].divisor});
      if (ge) t = t - {1'b0, st_r[k-1].divisor};
      st_nxt[k].rem = t[pgfn_pkg::FACTOR_W-1:0];
      st_nxt[k].num = {st_r[k-1].num[NSTEP-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NSTEP; k++) st_r[k].valid <= 1'b0;
    end else if (en) begin
      for (int k = 0; k <= NSTEP; k++) st_r[k] <= st_nxt[k];
    end
  end

  assign out_valid         = st_r[NSTEP].valid;
  assign dout.result_value = st_r[NSTEP].use_div ? st_r[NSTEP].num : st_r[NSTEP].res;
  assign dout.status       = st_r[NSTEP].status;

endmodule

FILE: design/pet_geometric_factor_normaliser.sv
// ----------------------------------------------------------------------------
// pet_geometric_factor_normaliser
// Geometric normalization of PET detector-pair counts against a factor table.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   valid/ready channel, one command per transfer. A load writes one
//          Q8.16 factor into the table; a normalize folds (det_a, det_b) into
//          the half-block, reads the factor and multiplies or divides the
//          Q16.16 count by it.
//   out_*  valid/ready channel, exactly one result per input transfer, in
//          order. Loads answer zero with status ok.
//   cfg_*  write-only register port (ring size, block size, apply mode);
//          write only while no item is in flight.
// Throughput: one item per cycle, sustained, while out_ready stays high.
// Path from input transfer to out_valid: 8 fold stages (a mod c
//   and b mod ring as compare-subtract steps), the table read, multiply and
//   dividend setup, the divider input register, 32 divider stages every item
//   passes through, and the output register.
// The factor table is one 8192 x 24 single-port RAM; load writes and lookups
//   use the port at the same stage, so a lookup sees every earlier load.
// Reset (rst_n low, synchronous) empties the pipe and restores the register
//   defaults; table contents are kept and unwritten entries are undefined.
// Receiver stall: the pipe freezes only once a two-entry output buffer is
//   full, so in_ready drops after a second result arrives while one is held.
// ----------------------------------------------------------------------------
module pet_geometric_factor_normaliser #(
  parameter int MAX_RING_DETECTORS = pgfn_pkg::MAX_RING_DETECTORS,
  parameter int MAX_HALF_BLOCK     = pgfn_pkg::MAX_HALF_BLOCK
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pgfn_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pgfn_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [pgfn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pgfn_pkg::CFG_W-1:0]        cfg_data
);

  localparam int NW    = $clog2(MAX_RING_DETECTORS+1);
  localparam int CW    = $clog2(2*MAX_HALF_BLOCK+1);
  localparam int DEPTH = MAX_HALF_BLOCK * MAX_RING_DETECTORS;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = pgfn_pkg::FACTOR_W;
  localparam int KW    = pgfn_pkg::COUNT_W;

  // ---------------------------------------------------------------- config
  logic [10:0] ring_r;
  logic [4:0]  blk_r;
  logic        mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r <= pgfn_pkg::RING_RESET;
      blk_r  <= pgfn_pkg::BLOCK_RESET;
      mode_r <= pgfn_pkg::MODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pgfn_pkg::CFG_RING:  ring_r <= cfg_data[10:0];
        pgfn_pkg::CFG_BLOCK: blk_r  <= cfg_data[4:0];
        pgfn_pkg::CFG_MODE:  mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp ring and block sizes into the supported ranges
  logic [31:0]   ring_w, blk_w;
  logic [NW-1:0] ring_n;
  logic [CW-1:0] blk_c;

  always_comb begin
    ring_w = 32'(ring_r);
    if (ring_w < 32'd2) ring_w = 32'd2;
    if (ring_w > 32'(MAX_RING_DETECTORS)) ring_w = 32'(MAX_RING_DETECTORS);
    blk_w = 32'(blk_r);
    if (blk_w < 32'd2) blk_w = 32'd2;
    if (blk_w > 32'(2*MAX_HALF_BLOCK)) blk_w = 32'(2*MAX_HALF_BLOCK);
    ring_n = NW'(ring_w);
    blk_c  = CW'(blk_w);
  end

  // ------------------------------------------------------- flow control
  // Whole pipe advances together; it stops only when the output buffer's
  // second entry is occupied.
  logic skid_valid_r;
  logic adv;
  logic in_acc;

  assign adv      = !skid_valid_r;
  assign in_ready = adv;
  assign in_acc   = in_valid && in_ready;

  // ------------------------------------------------------------ fold pipe
  pgfn_pkg::fold_ctl_t  f_ctl;
  logic [AW-1:0]        f_addr;
  logic [KW-1:0]        f_count;
  logic [FW-1:0]        f_wdata;

  pgfn_fold #(
    .MAXR (MAX_RING_DETECTORS),
    .MAXH (MAX_HALF_BLOCK)
  ) u_fold (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_acc  (in_acc),
    .in_item (in_data),
    .ring_n  (ring_n),
    .blk_c   (blk_c),
    .ctl     (f_ctl),
    .addr    (f_addr),
    .count   (f_count),
    .wdata   (f_wdata)
  );

  // ---------------------------------------------------------- factor table
  logic [FW-1:0] rdata;

  pgfn_ram #(
    .WIDTH (FW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .en    (adv),
    .we    (f_ctl.valid && f_ctl.we),
    .addr  (f_addr),
    .wdata (f_wdata),
    .rdata (rdata)
  );

  // m0: table data arrives, paired with the item's control
  logic          m0_valid_r, m0_load_r, m0_zero_r;
  logic [KW-1:0] m0_count_r;

  // m1: product and dividend setup
  logic          m1_valid_r, m1_load_r, m1_zero_r;
  logic [55:0]   m1_prod_r;
  logic [31:0]   m1_dlow_r;
  logic [16:0]   m1_dhigh_r;
  logic          m1_dovf_r, m1_fzero_r;
  logic [FW-1:0] m1_factor_r;

  logic [48:0]   dsum;
  assign dsum = {1'b0, m0_count_r, 16'b0} + 49'(rdata >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_valid_r <= 1'b0;
      m1_valid_r <= 1'b0;
    end else if (adv) begin
      m0_valid_r <= f_ctl.valid;
      m1_valid_r <= m0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m0_load_r   <= f_ctl.is_load;
      m0_zero_r   <= f_ctl.zero;
      m0_count_r  <= f_count;
      m1_load_r   <= m0_load_r;
      m1_zero_r   <= m0_zero_r;
      m1_prod_r   <= {24'b0, m0_count_r} * {32'b0, rdata};
      m1_dlow_r   <= dsum[31:0];
      m1_dhigh_r  <= dsum[48:32];
      m1_dovf_r   <= ({7'b0, dsum[48:32]} >= rdata);
      m1_fzero_r  <= (rdata == '0);
      m1_factor_r <= rdata;
    end
  end

  // m2: pick the outcome; only a clean divide uses the divider's quotient
  pgfn_pkg::div_item_t div_in;
  logic [56:0]         rsum;
  logic [40:0]         mres;

  always_comb begin
    rsum = {1'b0, m1_prod_r} + 57'(1 << (pgfn_pkg::FACTOR_FRAC_BITS - 1));
    mres = 41'(rsum >> pgfn_pkg::FACTOR_FRAC_BITS);
    div_in         = '0;
    div_in.valid   = m1_valid_r;
    div_in.num     = m1_dlow_r;
    div_in.rem     = {7'b0, m1_dhigh_r};
    div_in.divisor = m1_factor_r;
    if (m1_load_r) begin
      div_in.res    = '0;
      div_in.status = pgfn_pkg::ST_OK;
    end else if (m1_zero_r) begin
      div_in.res    = '0;
      div_in.status = pgfn_pkg::ST_ZERO;
    end else if (mode_r == pgfn_pkg::MODE_MUL) begin
      if (mres[40:32] != '0) begin
        div_in.res    = '1;
        div_in.status = pgfn_pkg::ST_OVF;
      end else begin
        div_in.res    = mres[31:0];
        div_in.status = pgfn_pkg::ST_OK;
      end
    end else if (m1_fzero_r) begin
      div_in.res    = '1;
      div_in.status = pgfn_pkg::ST_DIV0;
    end else if (m1_dovf_r) begin
      div_in.res    = '1;
      div_in.status = pgfn_pkg::ST_OVF;
    end else begin
      div_in.use_div = 1'b1;
      div_in.status  = pgfn_pkg::ST_OK;
    end
  end

  logic           d_valid;
  pgfn_pkg::out_t d_out;

  pgfn_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .din       (div_in),
    .out_valid (d_valid),
    .dout      (d_out)
  );

  // ------------------------------------------------------- output buffer
  logic           out_valid_r;
  pgfn_pkg::out_t out_data_r, skid_r;
  logic           push, pop;

  assign push = adv && d_valid;
  assign pop  = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_data_r <= skid_r;
        if (push) skid_r <= d_out;
      end else if (push) begin
        out_data_r <= d_out;
      end
    end else if (push) begin
      skid_r <= d_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/pgfn_checker.sv
// ----------------------------------------------------------------------------
// pgfn_checker
// Port-level checks of the normaliser, bound to the top level.
// ----------------------------------------------------------------------------
module pgfn_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input pgfn_pkg::out_t out_data
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // input side only backs up behind a stalled result
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("in_ready fell without an output stall");

  // passed zero count reads zero
  a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == pgfn_pkg::ST_ZERO) |-> out_data.result_value == '0)
    else $error("zero-count status with nonzero value");

  // saturation codes carry all ones
  a_sat_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.status == pgfn_pkg::ST_OVF) ||
                  (out_data.status == pgfn_pkg::ST_DIV0))
    |-> out_data.result_value == '1)
    else $error("saturated status without saturated value");

endmodule

bind pet_geometric_factor_normaliser pgfn_checker u_pgfn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PET geometric factor normalizer.
// ----------------------------------------------------------------------------
// Factor loads and pair normalizations stream through the valid/ready input.
// Every accepted transfer is run through a local model of the fold, the table
// lookup and the Q16.16 multiply/divide. The expected result is queued and
// compared in order against each output transfer. The register settings
// change between phases, and the idle pattern on both channels varies from
// phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_PER_PHASE = 66;
  localparam int NUM_PHASES     = 9;
  localparam int STALL_LIMIT    = 20000;
  localparam int MAXR           = pgfn_pkg::MAX_RING_DETECTORS;
  localparam int MAXH           = pgfn_pkg::MAX_HALF_BLOCK;
  localparam int TBL_DEPTH      = MAXH * MAXR;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  pgfn_pkg::in_t                  in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  pgfn_pkg::out_t                 out_data;
  logic                           cfg_we;
  logic [pgfn_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pgfn_pkg::CFG_W-1:0]     cfg_data;

  pet_geometric_factor_normaliser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Shadow copy of the registers and the factor table
  int          ring_cfg = 1024;
  int          block_cfg = 8;
  logic        mode_cfg = pgfn_pkg::MODE_MUL;
  logic [23:0] factor_tbl [0:TBL_DEPTH-1];
  // entries the stimulus has loaded; a lookup of any other entry is never sent
  bit          loaded [0:TBL_DEPTH-1];

  pgfn_pkg::in_t  pending_items[$];     // waiting to be driven
  pgfn_pkg::out_t expected_results[$];  // predicted, not yet seen at the output
  int   err_count = 0;
  int   snd_idle = 0;         // percent of cycles the sender holds back
  int   rcv_idle = 0;         // percent of cycles the receiver stalls

  // Table address of a pair: mirror-fold a into the half-block, move b along,
  // then wrap the folded b into the ring (true remainder, never negative).
  function automatic int fold_index(int a, int b);
    int n, c, fa, fb, col;
    n = ring_cfg;
    if (n < 2) n = 2;
    if (n > MAXR) n = MAXR;
    c = block_cfg;
    if (c < 2) c = 2;
    if (c > 2 * MAXH) c = 2 * MAXH;
    fa = a % c;
    fb = b - (a - fa);
    if (fa > c - 1 - fa) begin
      fa = c - 1 - fa;
      fb = -fb + c - 1;
    end
    col = fb % n;
    if (col < 0) col += n;
    return fa * MAXR + col;
  endfunction

  // Expected result of one transfer; a load also updates the shadow table.
  function automatic pgfn_pkg::out_t predict_normalised(pgfn_pkg::in_t it);
    pgfn_pkg::out_t r;
    logic [63:0]    cnt, fac, q;
    r   = '0;
    cnt = {32'd0, it.count_value};
    if (it.command == pgfn_pkg::CMD_LOAD) begin
      factor_tbl[{it.factor_row, it.factor_col}] = it.factor_value;
      r.status = pgfn_pkg::ST_OK;
      return r;
    end
    if (it.count_value == 32'd0) begin
      r.status = pgfn_pkg::ST_ZERO;
      return r;
    end
    fac = {40'd0, factor_tbl[fold_index(int'(it.det_a), int'(it.det_b))]};
    if (mode_cfg == pgfn_pkg::MODE_MUL) begin
      q = (cnt * fac + 64'd32768) >> pgfn_pkg::FACTOR_FRAC_BITS;
    end else if (fac == 64'd0) begin
      r.result_value = 32'hFFFF_FFFF;
      r.status = pgfn_pkg::ST_DIV0;
      return r;
    end else begin
      q = ((cnt << pgfn_pkg::FACTOR_FRAC_BITS) + (fac >> 1)) / fac;
    end
    if (q > 64'hFFFF_FFFF) begin
      r.result_value = 32'hFFFF_FFFF;
      r.status = pgfn_pkg::ST_OVF;
    end else begin
      r.result_value = q[31:0];
      r.status = pgfn_pkg::ST_OK;
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_count();
    case ($urandom_range(9))
      0:       return 32'd0;
      1, 2:    return 32'hFFFF_FFFF;
      3:       return 32'($urandom_range(1, 255));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] rand_factor();
    case ($urandom_range(9))
      0:       return 24'd0;
      1:       return 24'hFF_FFFF;
      2:       return 24'($urandom_range(1, 16));
      3:       return 24'h01_0000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic pgfn_pkg::in_t rand_item();
    pgfn_pkg::in_t it;
    logic [95:0]   raw;
    raw = {$urandom, $urandom, $urandom};
    it  = raw[$bits(pgfn_pkg::in_t)-1:0];
    return it;
  endfunction

  task automatic queue_load(int row, int col, logic [23:0] val);
    pgfn_pkg::in_t it;
    it = rand_item();
    it.command      = pgfn_pkg::CMD_LOAD;
    it.factor_row   = 3'(row);
    it.factor_col   = 10'(col);
    it.factor_value = val;
    loaded[row * MAXR + col] = 1'b1;
    pending_items.push_back(it);
  endtask

  // Normalize a pair; the entry it reads gets loaded first when it has never
  // been written or when fac_sel asks for a fresh factor (fac_sel >= 0).
  task automatic queue_pair(int a, int b, logic [31:0] cnt, int fac_sel);
    pgfn_pkg::in_t it;
    int            idx;
    idx = fold_index(a, b);
    if (fac_sel >= 0)
      queue_load(idx / MAXR, idx % MAXR, 24'(fac_sel));
    else if (!loaded[idx])
      queue_load(idx / MAXR, idx % MAXR, rand_factor());
    it = rand_item();
    it.command     = pgfn_pkg::CMD_NORM;
    it.det_a       = 10'(a);
    it.det_b       = 11'(b);
    it.count_value = cnt;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(logic [pgfn_pkg::CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= pgfn_pkg::CFG_W'(val);
    case (idx)
      pgfn_pkg::CFG_RING:  ring_cfg  = val & 32'h7FF;
      pgfn_pkg::CFG_BLOCK: block_cfg = val & 32'h1F;
      pgfn_pkg::CFG_MODE:  mode_cfg  = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver: a transfer is taken at the rising edge, the next item is offered
  // at the falling edge. Valid is held until its transfer.
  bit in_took;
  always @(posedge clk) begin
    in_took = 1'b0;
    if (rst_n && in_valid && in_ready) begin
      expected_results.push_back(predict_normalised(in_data));
      void'(pending_items.pop_front());
      in_took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      in_valid <= 1'b1;
    end else if (pending_items.size() > 0 && $urandom_range(99) >= snd_idle) begin
      in_valid <= 1'b1;
      in_data  <= pending_items[0];
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls driven at the falling edge
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= rcv_idle);
  end

  // Monitor: in-order compare of each output transfer
  always @(posedge clk) begin
    pgfn_pkg::out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $time,
                 out_data.result_value, out_data.status);
        err_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.result_value !== exp_r.result_value) begin
          $display("%0t: result_value expected %h actual %h", $time,
                   exp_r.result_value, out_data.result_value);
          err_count++;
        end
        if (out_data.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_r.status, out_data.status);
          err_count++;
        end
      end
    end
  end

  // Watchdog: cycles without any transfer while work is outstanding
  int stall_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_items.size() == 0 && expected_results.size() == 0))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Register settings per phase: ring, block, mode. Phase 0 keeps reset values.
  int ph_ring  [NUM_PHASES] = '{1024, 1024, 2, 0, 2047, 1000, 7, 1023, 1024};
  int ph_block [NUM_PHASES] = '{8, 8, 2, 0, 31, 5, 16, 3, 8};
  int ph_mode  [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0, 1};

  initial begin
    int a, b;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = pgfn_pkg::CFG_RING;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin snd_idle = 0;  rcv_idle = 0;  end
        1: begin snd_idle = 64; rcv_idle = 0;  end
        2: begin snd_idle = 0;  rcv_idle = 64; end
        default: begin snd_idle = 14; rcv_idle = 14; end
      endcase
      if (p > 0) begin
        write_reg(pgfn_pkg::CFG_RING, ph_ring[p]);
        write_reg(pgfn_pkg::CFG_BLOCK, ph_block[p]);
        write_reg(pgfn_pkg::CFG_MODE, ph_mode[p]);
      end

      if (p == 0) begin
        // multiply mode at reset settings
        queue_pair(0, 0, 32'h0001_0000, 24'h01_0000);         // unit factor
        queue_pair(0, 0, 32'd0, -1);                          // zero count
        queue_pair(1023, 2047, 32'hFFFF_FFFF, 24'hFF_FFFF);   // overflow
        queue_pair(1023, 0, 32'd1, 24'h00_8000);              // rounding tie
        queue_pair(4, 2047, 32'h0000_8000, 24'd0);            // zero factor
        queue_pair(512, 1024, 32'hFFFF_FFFF, 24'h01_0000);    // full count
        queue_pair(7, 3, 32'h1234_5678, 24'hAB_CDEF);         // folded row
        queue_load(7, 1023, 24'hFF_FFFF);                     // top corner
        queue_load(0, 0, 24'h01_0000);
      end else if (p == 1) begin
        // divide mode
        queue_pair(3, 5, 32'h0001_0000, 24'd0);               // divide by zero
        queue_pair(9, 2000, 32'hFFFF_FFFF, 24'd1);            // overflow
        queue_pair(7, 9, 32'd1, 24'd3);                       // rounding
        queue_pair(0, 0, 32'd0, -1);                          // zero count
        queue_pair(1023, 2047, 32'hFFFF_FFFF, 24'hFF_FFFF);
      end

      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if ($urandom_range(99) < 15) begin
          queue_load($urandom_range(7), $urandom_range(1023), rand_factor());
        end else begin
          a = ($urandom_range(9) == 0) ? 1023 * $urandom_range(1) : $urandom_range(1023);
          b = ($urandom_range(9) == 0) ? 2047 * $urandom_range(1) : $urandom_range(2047);
          queue_pair(a, b, rand_count(), ($urandom_range(99) < 40) ? int'(rand_factor()) : -1);
        end
      end

      // every transfer yields one result, so drained queues mean idle
      wait (pending_items.size() == 0 && expected_results.size() == 0);
      @(negedge clk);
    end

    repeat (60) @(posedge clk);
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
design/pgfn_pkg.sv
design/pgfn_ram.sv
design/pgfn_fold.sv
design/pgfn_divider.sv
design/pet_geometric_factor_normaliser.sv
design/pgfn_checker.sv
bench/tb_top.sv
